// File: rtl/core/lds_pkg.sv
// shared constants and types for the lambertian diffuse shader
package lds_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_BASE_RED = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BASE_GREEN = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BASE_BLUE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LIGHT_X = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LIGHT_Y = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LIGHT_Z = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_INTENSITY = 3'd6;

  localparam logic [31:0] LIGHT_Y_RESET = 32'd1310720;
  localparam logic [15:0] INTENSITY_RESET = 16'd4096;
  localparam logic [15:0] AMBIENT_Q16 = 16'd6554;

  localparam int unsigned InDataW = 144;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned DotW = 49;
  localparam int unsigned Len2W = 64;
  localparam int unsigned LenW = 32;
  localparam int unsigned CosW = 17;

  localparam int unsigned VecLat = 5;
  localparam int unsigned SqrtLat = 32;
  localparam int unsigned DivLat = 18;
  localparam int unsigned ColorLat = 3;
  localparam int unsigned TotalLat = VecLat + SqrtLat + DivLat + ColorLat;

  typedef logic [15:0] color_t;
  typedef logic signed [31:0] pos_t;
  typedef logic signed [15:0] nrm_t;

  typedef struct packed {
    color_t base_red;
    color_t base_green;
    color_t base_blue;
    pos_t   light_x;
    pos_t   light_y;
    pos_t   light_z;
    logic [15:0] intensity;
  } cfg_t;

endpackage

// File: rtl/core/lambertian_diffuse_shader.sv
// top level of the lambertian diffuse shader
//
// input beats on s_*: one surface point each, hit position (q16.16), unit
// normal (q2.14) in s_tdata and the shadow flag in s_tuser.
// output beats on m_*: shaded red, green, blue (q1.15, saturated).
// material and light registers are written through cfg_we/cfg_index/cfg_data
// by the user, who must do so only while no beat is in flight; the block
// itself does not enforce this. unknown indexes are ignored.
// a beat passes the light vector, dot product and squared length stages, the
// square root and cosine divide (one bit per stage each) and the color math.
// one beat per cycle unless stalled; every stage carries a valid bit.
// when m_tready is low with a beat on the output, the whole pipeline holds
// and s_tready goes low in the same cycle; nothing moves until that beat
// is taken.
// reset clears all valid bits and loads the register defaults
// (light at y = 20.0, intensity 1.0, black base color).
module lambertian_diffuse_shader (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // surface_x, surface_y, surface_z, normal_x, normal_y, normal_z
  input  logic [lds_pkg::InDataW-1:0] s_tdata,
  // shadowed
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // out_red, out_green, out_blue
  output logic [lds_pkg::OutDataW-1:0] m_tdata,
  input  logic cfg_we,
  input  logic [lds_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [lds_pkg::CfgDataW-1:0] cfg_data
);
  import lds_pkg::*;

  cfg_t cfg;
  logic en;
  logic in_go;
  logic vec_v, sqrt_v, div_v, col_v;
  logic signed [DotW-1:0] vec_dot, sqrt_dot;
  logic [Len2W-1:0] vec_len2;
  logic [LenW-1:0] len;
  logic [CosW-1:0] cosq;
  color_t red, green, blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_red <= '0;
      cfg.base_green <= '0;
      cfg.base_blue <= '0;
      cfg.light_x <= '0;
      cfg.light_y <= LIGHT_Y_RESET;
      cfg.light_z <= '0;
      cfg.intensity <= INTENSITY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_RED: cfg.base_red <= cfg_data[15:0];
        REG_BASE_GREEN: cfg.base_green <= cfg_data[15:0];
        REG_BASE_BLUE: cfg.base_blue <= cfg_data[15:0];
        REG_LIGHT_X: cfg.light_x <= cfg_data;
        REG_LIGHT_Y: cfg.light_y <= cfg_data;
        REG_LIGHT_Z: cfg.light_z <= cfg_data;
        REG_INTENSITY: cfg.intensity <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign en = !col_v || m_tready;
  assign s_tready = en;
  assign in_go = s_tvalid && en;

  lds_vec u_vec (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_go), .cfg(cfg),
    .sx(s_tdata[31:0]), .sy(s_tdata[63:32]), .sz(s_tdata[95:64]),
    .nx(s_tdata[111:96]), .ny(s_tdata[127:112]), .nz(s_tdata[143:128]),
    .in_shadow(s_tuser), .out_valid(vec_v), .dot(vec_dot), .len2(vec_len2)
  );

  lds_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(vec_v), .x_in(vec_len2),
    .dot_in(vec_dot), .out_valid(sqrt_v), .root_out(len), .dot_out(sqrt_dot)
  );

  lds_div u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(sqrt_v), .dot(sqrt_dot),
    .len(len), .out_valid(div_v), .cosq(cosq)
  );

  lds_color u_color (
    .clk(clk), .rst(rst), .en(en), .in_valid(div_v), .cfg(cfg), .cosq(cosq),
    .out_valid(col_v), .red(red), .green(green), .blue(blue)
  );

  assign m_tvalid = col_v;
  assign m_tdata = {blue, green, red};

`ifndef NO_ASSERTIONS
  logic [6:0] occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + 7'(s_tvalid && s_tready) - 7'(m_tvalid && m_tready);
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= 7'(TotalLat)) else $error("more beats in flight than stages");

  a_out_has_item: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> occ != 7'd0) else $error("output beat without accepted input");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("output valid right after reset");
`endif

endmodule

// File: rtl/core/lds_vec.sv
// light vector, scaling, dot product and squared length pipeline
module lds_vec (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  lds_pkg::cfg_t cfg,
  input  lds_pkg::pos_t sx,
  input  lds_pkg::pos_t sy,
  input  lds_pkg::pos_t sz,
  input  lds_pkg::nrm_t nx,
  input  lds_pkg::nrm_t ny,
  input  lds_pkg::nrm_t nz,
  input  logic in_shadow,
  output logic out_valid,
  output logic signed [lds_pkg::DotW-1:0] dot,
  output logic [lds_pkg::Len2W-1:0] len2
);
  import lds_pkg::*;

  logic [VecLat-1:0] v;
  logic [VecLat-2:0] sh;
  logic signed [32:0] l [3];
  logic [32:0] m [3];
  logic [2:0] sgn2;
  logic [30:0] mm [3];
  logic signed [31:0] c [3];
  logic signed [47:0] p [3];
  logic [61:0] q [3];
  nrm_t n1 [3], n2 [3], n3 [3];
  logic k;
  logic [30:0] mm_next [3];

  assign k = (m[0][32:31] != 2'b00) || (m[1][32:31] != 2'b00) || (m[2][32:31] != 2'b00);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mm_next[i] = k ? m[i][31:1] : m[i][30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[VecLat-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sh <= {sh[VecLat-3:0], in_shadow};
      l[0] <= $signed({cfg.light_x[31], cfg.light_x}) - $signed({sx[31], sx});
      l[1] <= $signed({cfg.light_y[31], cfg.light_y}) - $signed({sy[31], sy});
      l[2] <= $signed({cfg.light_z[31], cfg.light_z}) - $signed({sz[31], sz});
      n1[0] <= nx;
      n1[1] <= ny;
      n1[2] <= nz;
      for (int i = 0; i < 3; i++) begin
        m[i] <= l[i][32] ? 33'(-l[i]) : 33'(l[i]);
        sgn2[i] <= l[i][32];
        n2[i] <= n1[i];
        mm[i] <= mm_next[i];
        c[i] <= sgn2[i] ? -$signed({1'b0, mm_next[i]}) : $signed({1'b0, mm_next[i]});
        n3[i] <= n2[i];
        p[i] <= c[i] * n3[i];
        q[i] <= mm[i] * mm[i];
      end
      if (sh[VecLat-2]) begin
        dot <= '0;
      end else begin
        dot <= DotW'(p[0]) + DotW'(p[1]) + DotW'(p[2]);
      end
      len2 <= Len2W'(q[0]) + Len2W'(q[1]) + Len2W'(q[2]);
    end
  end

  assign out_valid = v[VecLat-1];

endmodule

// File: rtl/core/lds_sqrt.sv
// pipelined integer square root, one result bit per stage
module lds_sqrt (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [lds_pkg::Len2W-1:0] x_in,
  input  logic signed [lds_pkg::DotW-1:0] dot_in,
  output logic out_valid,
  output logic [lds_pkg::LenW-1:0] root_out,
  output logic signed [lds_pkg::DotW-1:0] dot_out
);
  import lds_pkg::*;

  logic [35:0] rem [SqrtLat+1];
  logic [LenW-1:0] root [SqrtLat+1];
  logic [Len2W-1:0] xs [SqrtLat+1];
  logic signed [DotW-1:0] dp [SqrtLat+1];
  logic [SqrtLat-1:0] v;

  assign rem[0] = '0;
  assign root[0] = '0;
  assign xs[0] = x_in;
  assign dp[0] = dot_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[SqrtLat-2:0], in_valid};
    end
  end

  for (genvar g = 0; g < SqrtLat; g++) begin : g_stage
    logic [35:0] rsh;
    logic [35:0] trial;
    logic ge;
    assign rsh = {rem[g][33:0], xs[g][Len2W-1:Len2W-2]};
    assign trial = {2'b00, root[g], 2'b01};
    assign ge = rsh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= ge ? rsh - trial : rsh;
        root[g+1] <= {root[g][LenW-2:0], ge};
        xs[g+1] <= {xs[g][Len2W-3:0], 2'b00};
        dp[g+1] <= dp[g];
      end
    end
  end

  assign out_valid = v[SqrtLat-1];
  assign root_out = root[SqrtLat];
  assign dot_out = dp[SqrtLat];

endmodule

// File: rtl/core/lds_div.sv
// pipelined restoring divider for the cosine, one quotient bit per stage
module lds_div (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [lds_pkg::DotW-1:0] dot,
  input  logic [lds_pkg::LenW-1:0] len,
  output logic out_valid,
  output logic [lds_pkg::CosW-1:0] cosq
);
  import lds_pkg::*;

  localparam int unsigned NumW = DotW - 1;

  logic [NumW-1:0] rem [CosW+1];
  logic [LenW-1:0] den [CosW+1];
  logic [CosW-1:0] qt [CosW+1];
  logic [CosW:0] v;
  logic use_div;

  assign use_div = !dot[DotW-1] && (dot != '0) && (len != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[CosW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= use_div ? dot[NumW-1:0] : '0;
      den[0] <= use_div ? len : LenW'(1);
      qt[0] <= '0;
    end
  end

  for (genvar g = 0; g < CosW; g++) begin : g_stage
    logic [NumW:0] sub;
    logic ge;
    assign sub = ({(NumW + 1 - LenW)'(0), den[g]} << (CosW - 1 - g));
    assign ge = {1'b0, rem[g]} >= sub;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= ge ? NumW'({1'b0, rem[g]} - sub) : rem[g];
        den[g+1] <= den[g];
        qt[g+1] <= {qt[g][CosW-2:0], ge};
      end
    end
  end

  assign out_valid = v[CosW];
  assign cosq = qt[CosW];

endmodule

// File: rtl/core/lds_color.sv
// ambient plus diffuse color per channel with saturation
module lds_color (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  lds_pkg::cfg_t cfg,
  input  logic [lds_pkg::CosW-1:0] cosq,
  output logic out_valid,
  output lds_pkg::color_t red,
  output lds_pkg::color_t green,
  output lds_pkg::color_t blue
);
  import lds_pkg::*;

  color_t base [3];
  color_t amb1 [3], amb2 [3];
  logic [32:0] t [3];
  logic [22:0] d [3];
  color_t res [3];
  logic [ColorLat-1:0] v;
  logic [31:0] amb_full [3];
  logic [48:0] u [3];
  logic [23:0] s [3];

  assign base[0] = cfg.base_red;
  assign base[1] = cfg.base_green;
  assign base[2] = cfg.base_blue;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amb_full[i] = base[i] * AMBIENT_Q16;
      u[i] = t[i] * cfg.intensity;
      s[i] = 24'(amb2[i]) + 24'(d[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[ColorLat-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t[i] <= base[i] * cosq;
        amb1[i] <= amb_full[i][31:16];
        d[i] <= u[i][48:26];
        amb2[i] <= amb1[i];
        res[i] <= (s[i][23:16] != 8'd0) ? 16'hFFFF : s[i][15:0];
      end
    end
  end

  assign out_valid = v[ColorLat-1];
  assign red = res[0];
  assign green = res[1];
  assign blue = res[2];

endmodule

// File: tb/tb_lambertian_diffuse_shader.sv
// testbench for the lambertian diffuse shader: random and directed surface points, color check
`timescale 1ns / 100ps

module tb_lambertian_diffuse_shader;
  import lds_pkg::*;

  typedef struct packed {
    logic        shadowed;
    nrm_t        nz;
    nrm_t        ny;
    nrm_t        nx;
    pos_t        sz;
    pos_t        sy;
    pos_t        sx;
  } point_t;

  typedef struct packed {
    color_t blue;
    color_t green;
    color_t red;
  } shade_t;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  lambertian_diffuse_shader u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  cfg_t   mat;
  point_t pending_points[$];
  shade_t expected_shades[$];
  int     errors = 0;
  int     shaded_count = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  longint cycles = 0;
  localparam longint CycleLimit = 400000;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic color_t shade_chan(color_t base, logic [63:0] cosq);
    logic [63:0] amb, dif, s;
    amb = (64'(base) * 64'(AMBIENT_Q16)) >> 16;
    dif = (64'(base) * cosq * 64'(mat.intensity)) >> 26;
    s = amb + dif;
    return (s > 64'd65535) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic shade_t shade_point(point_t p);
    longint l[3], c, dotp;
    longint n[3];
    logic [63:0] m[3], mx, len2, len, cosq;
    int k;
    shade_t r;
    l[0] = longint'(mat.light_x) - longint'(p.sx);
    l[1] = longint'(mat.light_y) - longint'(p.sy);
    l[2] = longint'(mat.light_z) - longint'(p.sz);
    n[0] = longint'(p.nx);
    n[1] = longint'(p.ny);
    n[2] = longint'(p.nz);
    cosq = 0;
    if (!p.shadowed) begin
      dotp = 0;
      len2 = 0;
      for (int i = 0; i < 3; i++) m[i] = (l[i] < 0) ? -l[i] : l[i];
      mx = m[0];
      if (m[1] > mx) mx = m[1];
      if (m[2] > mx) mx = m[2];
      k = (mx >= 64'h8000_0000) ? 1 : 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = m[i] >> k;
        c = (l[i] < 0) ? -longint'(m[i]) : longint'(m[i]);
        dotp += c * n[i];
        len2 += m[i] * m[i];
      end
      len = int_sqrt(len2);
      if (len != 0 && dotp > 0) cosq = 64'(dotp) / len;
    end
    r.red = shade_chan(mat.base_red, cosq);
    r.green = shade_chan(mat.base_green, cosq);
    r.blue = shade_chan(mat.base_blue, cosq);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_shades.push_back(shade_point(point_t'({s_tuser, s_tdata})));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          point_t p;
          p = pending_points.pop_front();
          {s_tuser, s_tdata} <= p;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        shade_t got, want;
        got = m_tdata;
        if (expected_shades.size() == 0) begin
          $display("output beat with no point pending");
          errors++;
        end else begin
          want = expected_shades.pop_front();
          if (got.red !== want.red) report_mismatch("red", got.red, want.red);
          if (got.green !== want.green) report_mismatch("green", got.green, want.green);
          if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
          shaded_count++;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BASE_RED: mat.base_red = val[15:0];
      REG_BASE_GREEN: mat.base_green = val[15:0];
      REG_BASE_BLUE: mat.base_blue = val[15:0];
      REG_LIGHT_X: mat.light_x = val;
      REG_LIGHT_Y: mat.light_y = val;
      REG_LIGHT_Z: mat.light_z = val;
      REG_INTENSITY: mat.intensity = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_points.size() > 0 || s_tvalid || expected_shades.size() > 0)
      @(posedge clk);
    repeat (TotalLat + 10) @(posedge clk);
  endtask

  function automatic point_t rand_point();
    point_t p;
    p = 145'({$urandom, $urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(3))
      0: begin
        // normal components in [-1.0, 1.0), moderate positions
        p.nx = $signed(16'($urandom_range(32767))) - 16'sd16384;
        p.ny = $signed(16'($urandom_range(32767))) - 16'sd16384;
        p.nz = $signed(16'($urandom_range(32767))) - 16'sd16384;
        p.sx = $signed(32'($urandom_range(32'h00FF_FFFF))) - 32'sh0080_0000;
        p.sy = $signed(32'($urandom_range(32'h00FF_FFFF))) - 32'sh0080_0000;
        p.sz = $signed(32'($urandom_range(32'h00FF_FFFF))) - 32'sh0080_0000;
      end
      1: begin
        p.nx = 0; p.ny = 16'sd16384; p.nz = 0;
        p.sx = $signed(32'($urandom_range(32'h0FFF_FFFF))) - 32'sh0800_0000;
        p.sz = $signed(32'($urandom_range(32'h0FFF_FFFF))) - 32'sh0800_0000;
        p.sy = -p.sy[31:0] >>> 4;
      end
      default: ;
    endcase
    p.shadowed = ($urandom_range(4) == 0);
    return p;
  endfunction

  task automatic random_phase(int cnt);
    for (int i = 0; i < cnt; i++) pending_points.push_back(rand_point());
    drain();
  endtask

  initial begin
    point_t p;
    mat = '0;
    mat.light_y = LIGHT_Y_RESET;
    mat.intensity = INTENSITY_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // defaults: black base gives zero everywhere
    p = '0; p.ny = 16'sd16384;
    pending_points.push_back(p);
    drain();

    write_reg(REG_BASE_RED, 32'hFFFF);
    write_reg(REG_BASE_GREEN, 32'h4000);
    write_reg(REG_BASE_BLUE, 32'h0001);
    write_reg(RegUnused, 32'h1234);
    // directed points
    p = '0; p.ny = 16'sd16384; pending_points.push_back(p);
    p.shadowed = 1'b1; pending_points.push_back(p);
    p = '0; p.sy = LIGHT_Y_RESET; p.ny = 16'sd16384; pending_points.push_back(p);
    p = '0; p.ny = -16'sd16384; pending_points.push_back(p);
    p = '0; p.ny = 16'sh7FFF; pending_points.push_back(p);
    p = '0; p.nx = -16'sh8000; p.ny = -16'sh8000; p.nz = -16'sh8000; pending_points.push_back(p);
    p = '0; p.sx = 32'sh7FFF_FFFF; p.sy = -32'sh8000_0000; p.sz = 32'sh7FFF_FFFF;
    p.nx = 16'sh7FFF; p.ny = 16'sh7FFF; p.nz = 16'sh7FFF; pending_points.push_back(p);
    p = '0; p.sx = -32'sh8000_0000; p.sy = 32'sh7FFF_FFFF; p.sz = -32'sh8000_0000;
    p.nx = 16'sh7FFF; p.ny = -16'sh8000; p.nz = 16'sh7FFF; pending_points.push_back(p);
    p = '1; p.shadowed = 1'b0; pending_points.push_back(p);
    p = '0; p.sx = 32'sh0001_0000; p.ny = 16'sd11585; p.nx = -16'sd11585; pending_points.push_back(p);
    drain();

    write_reg(REG_INTENSITY, 32'hFFFF);
    write_reg(REG_LIGHT_X, 32'h7FFF_FFFF);
    write_reg(REG_LIGHT_Y, 32'h8000_0000);
    write_reg(REG_LIGHT_Z, 32'h7FFF_FFFF);
    p = '0; p.sx = -32'sh8000_0000; p.sy = 32'sh7FFF_FFFF; p.sz = -32'sh8000_0000;
    p.nx = 16'sd16384; p.ny = -16'sd16384; p.nz = 16'sd16384; pending_points.push_back(p);
    p.shadowed = 1'b1; pending_points.push_back(p);
    p = '0; pending_points.push_back(p);
    drain();

    send_idle_pct = 14; recv_idle_pct = 66;
    write_reg(REG_INTENSITY, 32'h0000);
    write_reg(REG_LIGHT_X, 32'h0);
    write_reg(REG_LIGHT_Y, 32'h0);
    write_reg(REG_LIGHT_Z, 32'h0);
    random_phase(100);

    write_reg(REG_INTENSITY, 32'(INTENSITY_RESET));
    write_reg(REG_LIGHT_Y, LIGHT_Y_RESET);
    write_reg(REG_BASE_BLUE, 32'h8000);
    random_phase(200);

    send_idle_pct = 66; recv_idle_pct = 14;
    write_reg(REG_BASE_RED, $urandom_range(16'hFFFF));
    write_reg(REG_BASE_GREEN, $urandom_range(16'hFFFF));
    write_reg(REG_BASE_BLUE, $urandom_range(16'hFFFF));
    write_reg(REG_LIGHT_X, $urandom);
    write_reg(REG_LIGHT_Z, $urandom);
    write_reg(REG_INTENSITY, $urandom_range(16'hFFFF));
    random_phase(300);

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_BASE_RED, 32'h0);
    write_reg(REG_BASE_GREEN, 32'hFFFF);
    write_reg(REG_LIGHT_X, 32'h0);
    write_reg(REG_LIGHT_Y, 32'h0050_0000);
    write_reg(REG_LIGHT_Z, 32'hFFF0_0000);
    write_reg(REG_INTENSITY, 32'h2000);
    random_phase(330);

    $display("shaded %0d points across several material and light settings", shaded_count);
    $display("covered shadow, back facing, coincident light and saturation cases");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/lds_pkg.sv
rtl/core/lds_vec.sv
rtl/core/lds_sqrt.sv
rtl/core/lds_div.sv
rtl/core/lds_color.sv
rtl/core/lambertian_diffuse_shader.sv
tb/tb_lambertian_diffuse_shader.sv
